// ----- rtl/core/rtt_pkg.sv -----
// shared types and constants for the repeating timer task table
// no dependencies; imported by rtt_alu and repeating_timer_task_table
package rtt_pkg;

  // table geometry
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // field widths fixed by the item format
  localparam int TIME_W = 32;
  localparam int IVAL_W = 24;
  localparam int REM_W  = 16;
  localparam int TAG_W  = 8;
  localparam int LIVE_W = 5;

  // command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic                     command;
    logic [TIME_W-1:0]        current_time;
    logic [IVAL_W-1:0]        interval;
    logic signed [REM_W-1:0]  repeat_count;
    logic [TAG_W-1:0]         task_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TAG_W-1:0]  fired_tag;
    logic [LIVE_W-1:0] live_tasks;
    logic              last;
  } out_item_t;

  // one stored timer task
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [IVAL_W-1:0] interval;
    logic [REM_W-1:0]  remaining;
    logic [TIME_W-1:0] deadline;
  } slot_t;

endpackage

// ----- rtl/core/rtt_alu.sv -----
// shared time unit: saturating deadline add and due compare
// depends on rtt_pkg
module rtt_alu (
  input  logic [rtt_pkg::TIME_W-1:0] base_i,
  input  logic [rtt_pkg::IVAL_W-1:0] step_i,
  input  logic [rtt_pkg::TIME_W-1:0] now_i,
  output logic [rtt_pkg::TIME_W-1:0] sum_o,
  output logic                       due_o
);
  import rtt_pkg::*;

  logic [TIME_W:0] raw_sum;

  // add with carry out, clamp to all ones on overflow
  assign raw_sum = {1'b0, base_i} + {{(TIME_W + 1 - IVAL_W){1'b0}}, step_i};
  assign sum_o   = raw_sum[TIME_W] ? {TIME_W{1'b1}} : raw_sum[TIME_W-1:0];

  // deadline reached
  assign due_o = (now_i >= base_i);

endmodule

// ----- rtl/core/repeating_timer_task_table.sv -----
// Repeating timer task table, top level with sequencer and slot memory.
// Depends on rtt_pkg and rtt_alu.
//
// An add gives its single result from the ADD state. For an update the sequencer
// walks the slot memory one task per cycle through its registered read port,
// checking each deadline and advancing due ones in the shared adder and
// compacting survivors in place, then gives the update-done result; an empty
// table goes straight to it. busy is high for the whole walk.
// Results appear as one-cycle out_valid strobes that cannot be held off;
// fired results come in insertion order and the done result carries last.
module repeating_timer_task_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rtt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rtt_pkg::out_item_t out_item
);
  import rtt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]       state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  slot_t            slot_mem_r [SLOTS];
  slot_t            rd_slot_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_slot;

  logic [TIME_W-1:0] alu_base;
  logic [IVAL_W-1:0] alu_step;
  logic [TIME_W-1:0] alu_sum;
  logic              alu_due;

  logic [REM_W-1:0]  rem_new;
  logic [CNT_W-1:0]  idx_next_cnt;
  logic [CNT_W-1:0]  count_inc;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // shared adder/compare: new task deadline on add, slot deadline on walk
  assign alu_base = (state_r == ST_ADD) ? item_r.current_time : rd_slot_r.deadline;
  assign alu_step = (state_r == ST_ADD) ? item_r.interval : rd_slot_r.interval;

  rtt_alu u_alu (
    .base_i (alu_base),
    .step_i (alu_step),
    .now_i  (item_r.current_time),
    .sum_o  (alu_sum),
    .due_o  (alu_due)
  );

  // count down only a positive remaining count of a task that fires
  assign rem_new = (alu_due && (rd_slot_r.remaining != '0) && !rd_slot_r.remaining[REM_W-1])
                 ? rd_slot_r.remaining - REM_W'(1) : rd_slot_r.remaining;

  assign idx_next_cnt = CNT_W'(idx_r) + CNT_W'(1);
  assign count_inc    = count_r + CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_slot       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          w_nxt    = '0;
          idx_nxt  = '0;
          if (in_item.command == CMD_ADD) begin
            state_nxt = ST_ADD;
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_ADD: begin
        out_valid_nxt     = 1'b1;
        out_item_nxt.last = 1'b1;
        if (count_r >= CNT_W'(SLOTS)) begin
          out_item_nxt.kind       = KIND_FULL;
          out_item_nxt.live_tasks = LIVE_W'(count_r);
        end else begin
          wr_en                   = 1'b1;
          wr_addr                 = count_r[IDX_W-1:0];
          wr_slot.tag             = item_r.task_tag;
          wr_slot.interval        = item_r.interval;
          wr_slot.remaining       = item_r.repeat_count;
          wr_slot.deadline        = alu_sum;
          count_nxt               = count_inc;
          out_item_nxt.kind       = KIND_ADDED;
          out_item_nxt.live_tasks = LIVE_W'(count_inc);
        end
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        // survivors move down to the write pointer, never past the read point
        if (rem_new != '0) begin
          wr_en             = 1'b1;
          wr_addr           = w_r[IDX_W-1:0];
          wr_slot.tag       = rd_slot_r.tag;
          wr_slot.interval  = rd_slot_r.interval;
          wr_slot.remaining = rem_new;
          wr_slot.deadline  = alu_due ? alu_sum : rd_slot_r.deadline;
          w_nxt             = w_r + CNT_W'(1);
        end
        if (alu_due) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.kind       = KIND_FIRED;
          out_item_nxt.fired_tag  = rd_slot_r.tag;
          out_item_nxt.live_tasks = LIVE_W'(count_r);
        end
        if (idx_next_cnt == count_r) begin
          state_nxt = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_next_cnt[IDX_W-1:0];
          idx_nxt = idx_next_cnt[IDX_W-1:0];
        end
      end
      ST_DONE: begin
        count_nxt               = w_r;
        out_valid_nxt           = 1'b1;
        out_item_nxt.kind       = KIND_DONE;
        out_item_nxt.live_tasks = LIVE_W'(w_r);
        out_item_nxt.last       = 1'b1;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot_r <= slot_mem_r[rd_addr];
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("task count above table size");

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_FIRED) |-> !out_item.last)
    else $error("fired result marked last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && wr_en |-> (w_r <= CNT_W'(idx_r)))
    else $error("compaction write ahead of walk");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_DONE)
      |-> (CNT_W'(out_item.live_tasks) == count_r))
    else $error("done result count differs from table count");

endmodule
